/* hdl/tobpc_pkg.sv */
// tobpc_pkg: shared types and constants of the top-of-book price cache
// no dependencies; imported by every module of the block

package tobpc_pkg;

  localparam int NUM_BOOKS_DEF   = 16;
  localparam int MAX_LEVELS_DEF  = 32;
  localparam int PRICE_WIDTH_DEF = 48;

  localparam int ID_W    = 4;
  localparam int LEVEL_W = 6;

  typedef enum logic [2:0] {
    CMD_REGISTER  = 3'd0,
    CMD_SNAPSHOT  = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_QUERY_OWN = 3'd3,
    CMD_QUERY_EXT = 3'd4
  } cmd_t;

  localparam logic [1:0] SIDE_BID   = 2'd0;
  localparam logic [1:0] SIDE_OFFER = 2'd1;

  // classified item as it sits in the queue (price travels beside it)
  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] book_id;
    logic            in_table;
    logic            id_present;
    logic [1:0]      side;
    logic            price_present;
    logic            first;
    logic            last;
  } ctrl_t;

endpackage

/* hdl/tobpc_if.sv */
// tobpc_in_if / tobpc_out_if: valid/ready channels of the price cache
// depends on tobpc_pkg for field widths

interface tobpc_in_if import tobpc_pkg::*; #(
  parameter int PW = PRICE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           command;
  logic [ID_W-1:0]      book_id;
  logic                 id_present;
  logic [1:0]           entry_side;
  logic                 price_present;
  logic signed [PW-1:0] price;
  logic                 first_entry;
  logic                 last_item;

  modport source (output valid, command, book_id, id_present, entry_side, price_present,
                  price, first_entry, last_item, input ready);
  modport sink (input valid, command, book_id, id_present, entry_side, price_present,
                price, first_entry, last_item, output ready);
endinterface

interface tobpc_out_if import tobpc_pkg::*; #(
  parameter int PW = PRICE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 best_bid_valid;
  logic signed [PW-1:0] best_bid;
  logic                 best_offer_valid;
  logic signed [PW-1:0] best_offer;
  logic [LEVEL_W-1:0]   bid_levels;
  logic [LEVEL_W-1:0]   offer_levels;

  modport source (output valid, best_bid_valid, best_bid, best_offer_valid, best_offer,
                  bid_levels, offer_levels, input ready);
  modport sink (input valid, best_bid_valid, best_bid, best_offer_valid, best_offer,
                bid_levels, offer_levels, output ready);
endinterface

/* hdl/top_of_book_price_cache_core.sv */
// top_of_book_price_cache_core: top level of the top-of-book price cache
// depends on tobpc_pkg, tobpc_if, tobpc_front and tobpc_back
//
//   channel | dir | handshake         | carries
//   in_ch   | in  | valid/ready       | command, book, snapshot entry or query item
//   out_ch  | out | valid/ready       | aggregate best bid/offer and own levels
//
// register, clear and query items pass through idle and exec in the back end
// a priced snapshot entry passes through idle, exec and a search of the stored levels
// on its side (one level compared per cycle); a last entry then passes through commit
// a two-entry queue lets the front accept while the back works or waits on out_ch
// rst_n is synchronous; books come up unregistered with no clearing pass

module top_of_book_price_cache_core import tobpc_pkg::*; #(
  parameter int NUM_BOOKS   = NUM_BOOKS_DEF,
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tobpc_in_if.sink     in_ch,
  tobpc_out_if.source  out_ch
);

  logic                          head_valid, pop;
  ctrl_t                         head_ctrl;
  logic signed [PRICE_WIDTH-1:0] head_price;

  tobpc_front #(
    .NUM_BOOKS  (NUM_BOOKS),
    .PRICE_WIDTH(PRICE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .head_valid(head_valid),
    .head_ctrl (head_ctrl),
    .head_price(head_price),
    .pop       (pop)
  );

  tobpc_back #(
    .NUM_BOOKS  (NUM_BOOKS),
    .MAX_LEVELS (MAX_LEVELS),
    .PRICE_WIDTH(PRICE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_ctrl (head_ctrl),
    .head_price(head_price),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

/* hdl/tobpc_front.sv */
// tobpc_front: accepts items, classifies them and queues them for the back end
// depends on tobpc_pkg and tobpc_in_if

module tobpc_front import tobpc_pkg::*; #(
  parameter int NUM_BOOKS   = NUM_BOOKS_DEF,
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tobpc_in_if.sink                      in_ch,
  output logic                          head_valid,
  output ctrl_t                         head_ctrl,
  output logic signed [PRICE_WIDTH-1:0] head_price,
  input  logic                          pop
);

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;

  ctrl_t                         q_ctrl_r [DEPTH];
  logic signed [PRICE_WIDTH-1:0] q_price_r [DEPTH];
  logic [PTR_W-1:0]              wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]                fill_r;
  logic                          accept, push, useful;
  ctrl_t                         cls;

  assign in_ch.ready = (fill_r != (PTR_W+1)'(DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cls               = '0;
    cls.cmd           = cmd_t'(in_ch.command);
    cls.book_id       = in_ch.book_id;
    cls.in_table      = (32'(in_ch.book_id) < 32'(NUM_BOOKS));
    cls.id_present    = in_ch.id_present;
    cls.side          = in_ch.entry_side;
    cls.price_present = in_ch.price_present;
    cls.first         = in_ch.first_entry;
    cls.last          = in_ch.last_item;
    case (in_ch.command)
      CMD_REGISTER, CMD_SNAPSHOT, CMD_CLEAR, CMD_QUERY_OWN, CMD_QUERY_EXT: useful = 1'b1;
      default: useful = 1'b0;
    endcase
  end

  // unused command codes are taken and dropped here
  assign push = accept && useful;

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctrl_r[wr_ptr_r]  <= cls;
      q_price_r[wr_ptr_r] <= in_ch.price;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  assign head_valid = (fill_r != '0);
  assign head_ctrl  = q_ctrl_r[rd_ptr_r];
  assign head_price = q_price_r[rd_ptr_r];

endmodule

/* hdl/tobpc_back.sv */
// tobpc_back: executes queued items against the book table, staging and query
// depends on tobpc_pkg and tobpc_out_if

module tobpc_back import tobpc_pkg::*; #(
  parameter int NUM_BOOKS   = NUM_BOOKS_DEF,
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  ctrl_t                         head_ctrl,
  input  logic signed [PRICE_WIDTH-1:0] head_price,
  output logic                          pop,
  tobpc_out_if.source                   out_ch
);

  localparam int PW    = PRICE_WIDTH;
  localparam int IDX_W = (NUM_BOOKS > 1) ? $clog2(NUM_BOOKS) : 1;
  localparam int LW    = $clog2(MAX_LEVELS + 1);
  localparam int LA_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int BW    = 2 * PW + 2 + 2 * LW;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SRCH   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t                state_r;
  ctrl_t                 item_r;
  logic signed [PW-1:0]  price_r;
  logic [NUM_BOOKS-1:0]  present_r;

  // book table: {bid_valid, bid, offer_valid, offer, bid_cnt, offer_cnt}
  logic [BW-1:0]         book_mem [NUM_BOOKS];
  logic [BW-1:0]         book_q_r;
  logic                  bk_we;
  logic [IDX_W-1:0]      bk_wa;
  logic [BW-1:0]         bk_wd;

  logic signed [PW-1:0]  seen_bid_mem [MAX_LEVELS];
  logic signed [PW-1:0]  seen_offer_mem [MAX_LEVELS];
  logic signed [PW-1:0]  seen_bid_q_r, seen_offer_q_r;
  logic                  sn_re;
  logic [LA_W-1:0]       sn_ra;
  logic                  sn_we_bid, sn_we_offer;
  logic [LA_W-1:0]       sn_wa;

  logic [LW-1:0]         srch_i_r;
  logic [LW-1:0]         st_bcnt_r, st_ocnt_r;
  logic signed [PW-1:0]  st_bid_r, st_offer_r;
  logic [ID_W-1:0]       st_book_r;

  logic                  q_bv_r, q_ov_r;
  logic signed [PW-1:0]  q_bid_r, q_offer_r;
  logic [LW-1:0]         q_bl_r, q_ol_r;

  logic                  o_valid_r, o_bv_r, o_ov_r;
  logic signed [PW-1:0]  o_bid_r, o_offer_r;
  logic [LEVEL_W-1:0]    o_bl_r, o_ol_r;

  logic                  b_bv, b_ov;
  logic signed [PW-1:0]  b_bid, b_offer;
  logic [LW-1:0]         b_bcnt, b_ocnt;
  logic [IDX_W-1:0]      idx, st_idx;
  logic                  known, st_known, out_free, is_offer, emit;
  logic [LW-1:0]         n_cnt;
  logic signed [PW-1:0]  seen_q;
  logic                  n_bv, n_ov;
  logic signed [PW-1:0]  n_bid, n_offer;
  logic [LW-1:0]         n_bl, n_ol;

  assign {b_bv, b_bid, b_ov, b_offer, b_bcnt, b_ocnt} = book_q_r;

  assign idx      = IDX_W'(item_r.book_id);
  assign known    = item_r.in_table && present_r[idx];
  assign st_idx   = IDX_W'(st_book_r);
  assign st_known = (32'(st_book_r) < 32'(NUM_BOOKS)) && present_r[st_idx];
  assign out_free = !o_valid_r || out_ch.ready;
  assign is_offer = (item_r.side == SIDE_OFFER);
  assign n_cnt    = is_offer ? st_ocnt_r : st_bcnt_r;
  assign seen_q   = is_offer ? seen_offer_q_r : seen_bid_q_r;
  assign pop      = (state_r == ST_IDLE) && head_valid;
  assign emit     = (state_r == ST_EXEC) && item_r.last && out_free &&
                    (item_r.cmd == CMD_QUERY_OWN || item_r.cmd == CMD_QUERY_EXT);

  // query fold for the current item
  always_comb begin
    n_bv = q_bv_r; n_bid = q_bid_r; n_ov = q_ov_r; n_offer = q_offer_r;
    n_bl = q_bl_r; n_ol = q_ol_r;
    if (item_r.cmd == CMD_QUERY_OWN) begin
      n_bv = 1'b0; n_bid = '0; n_ov = 1'b0; n_offer = '0; n_bl = '0; n_ol = '0;
      if (known) begin
        n_bv = b_bv; n_bid = b_bid; n_ov = b_ov; n_offer = b_offer;
        n_bl = b_bcnt; n_ol = b_ocnt;
      end
    end else if (known) begin
      if (b_bv && (!q_bv_r || (b_bid > q_bid_r))) begin
        n_bv = 1'b1; n_bid = b_bid;
      end
      if (b_ov && (!q_ov_r || (q_offer_r > b_offer))) begin
        n_ov = 1'b1; n_offer = b_offer;
      end
    end
  end

  // table writes: register and clear write an empty book, commit the staging
  always_comb begin
    bk_we = 1'b0;
    bk_wa = idx;
    bk_wd = '0;
    if (state_r == ST_EXEC) begin
      if (item_r.cmd == CMD_REGISTER) bk_we = item_r.in_table && !present_r[idx];
      if (item_r.cmd == CMD_CLEAR)    bk_we = known;
    end else if (state_r == ST_COMMIT) begin
      bk_we = item_r.id_present && st_known;
      bk_wa = st_idx;
      bk_wd = {st_bcnt_r != '0, st_bid_r, st_ocnt_r != '0, st_offer_r, st_bcnt_r, st_ocnt_r};
    end
  end

  always_comb begin
    sn_re       = 1'b0;
    sn_ra       = '0;
    sn_we_bid   = 1'b0;
    sn_we_offer = 1'b0;
    sn_wa       = LA_W'(n_cnt);
    if (pop) begin
      sn_re = 1'b1;
    end else if (state_r == ST_SRCH) begin
      if (srch_i_r == n_cnt) begin
        sn_we_bid   = !is_offer && (n_cnt < LW'(MAX_LEVELS));
        sn_we_offer = is_offer && (n_cnt < LW'(MAX_LEVELS));
      end else if (seen_q != price_r && (srch_i_r + 1'b1) < n_cnt) begin
        sn_re = 1'b1;
        sn_ra = LA_W'(srch_i_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bk_we) book_mem[bk_wa] <= bk_wd;
    if (pop)   book_q_r <= book_mem[IDX_W'(head_ctrl.book_id)];
    if (sn_we_bid)   seen_bid_mem[sn_wa] <= price_r;
    if (sn_we_offer) seen_offer_mem[sn_wa] <= price_r;
    if (sn_re) begin
      seen_bid_q_r   <= seen_bid_mem[sn_ra];
      seen_offer_q_r <= seen_offer_mem[sn_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      present_r  <= '0;
      st_bcnt_r  <= '0;
      st_ocnt_r  <= '0;
      st_bid_r   <= '0;
      st_offer_r <= '0;
      st_book_r  <= '0;
      q_bv_r     <= 1'b0;
      q_ov_r     <= 1'b0;
      q_bid_r    <= '0;
      q_offer_r  <= '0;
      q_bl_r     <= '0;
      q_ol_r     <= '0;
      o_valid_r  <= 1'b0;
      srch_i_r   <= '0;
    end else begin
      if (emit) o_valid_r <= 1'b1;
      else if (o_valid_r && out_ch.ready) o_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (head_valid) begin
            item_r   <= head_ctrl;
            price_r  <= head_price;
            srch_i_r <= '0;
            if (head_ctrl.cmd == CMD_SNAPSHOT && head_ctrl.first) begin
              st_bcnt_r  <= '0;
              st_ocnt_r  <= '0;
              st_bid_r   <= '0;
              st_offer_r <= '0;
              st_book_r  <= head_ctrl.book_id;
            end
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (item_r.cmd)
            CMD_REGISTER: begin
              if (item_r.in_table) present_r[idx] <= 1'b1;
              state_r <= ST_IDLE;
            end
            CMD_SNAPSHOT: begin
              if (item_r.price_present && item_r.side == SIDE_BID) begin
                if (st_bcnt_r == '0 || price_r > st_bid_r) st_bid_r <= price_r;
                state_r <= ST_SRCH;
              end else if (item_r.price_present && item_r.side == SIDE_OFFER) begin
                if (st_ocnt_r == '0 || st_offer_r > price_r) st_offer_r <= price_r;
                state_r <= ST_SRCH;
              end else begin
                state_r <= item_r.last ? ST_COMMIT : ST_IDLE;
              end
            end
            CMD_QUERY_OWN, CMD_QUERY_EXT: begin
              if (!item_r.last) begin
                q_bv_r <= n_bv; q_bid_r <= n_bid; q_ov_r <= n_ov; q_offer_r <= n_offer;
                q_bl_r <= n_bl; q_ol_r <= n_ol;
                state_r <= ST_IDLE;
              end else if (out_free) begin
                o_bv_r    <= n_bv;
                o_bid_r   <= n_bid;
                o_ov_r    <= n_ov;
                o_offer_r <= n_offer;
                o_bl_r    <= LEVEL_W'(n_bl);
                o_ol_r    <= LEVEL_W'(n_ol);
                q_bv_r <= 1'b0; q_bid_r <= '0; q_ov_r <= 1'b0; q_offer_r <= '0;
                q_bl_r <= '0; q_ol_r <= '0;
                state_r <= ST_IDLE;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_SRCH: begin
          // one stored level compared per cycle
          if (srch_i_r == n_cnt) begin
            if (n_cnt < LW'(MAX_LEVELS)) begin
              if (is_offer) st_ocnt_r <= st_ocnt_r + 1'b1;
              else          st_bcnt_r <= st_bcnt_r + 1'b1;
            end
            state_r <= item_r.last ? ST_COMMIT : ST_IDLE;
          end else if (seen_q == price_r) begin
            state_r <= item_r.last ? ST_COMMIT : ST_IDLE;
          end else begin
            srch_i_r <= srch_i_r + 1'b1;
          end
        end
        ST_COMMIT: begin
          st_bcnt_r  <= '0;
          st_ocnt_r  <= '0;
          st_bid_r   <= '0;
          st_offer_r <= '0;
          state_r    <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = o_valid_r;
  assign out_ch.best_bid_valid   = o_bv_r;
  assign out_ch.best_bid         = o_bid_r;
  assign out_ch.best_offer_valid = o_ov_r;
  assign out_ch.best_offer       = o_offer_r;
  assign out_ch.bid_levels       = o_bl_r;
  assign out_ch.offer_levels     = o_ol_r;

endmodule

/* hdl/tobpc_checker.sv */
// tobpc_checker: port-level assertions on the price cache results
// depends on tobpc_pkg; bound to top_of_book_price_cache_core below

module tobpc_checker import tobpc_pkg::*; #(
  parameter int PW = PRICE_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input logic          bid_valid,
  input logic [PW-1:0] bid,
  input logic          offer_valid,
  input logic [PW-1:0] offer
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !bid_valid |-> bid == '0)
    else $error("best bid not zero without a bid");

  a_offer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !offer_valid |-> offer == '0)
    else $error("best offer not zero without an offer");

endmodule

bind top_of_book_price_cache_core tobpc_checker #(.PW(PRICE_WIDTH)) u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .bid_valid  (out_ch.best_bid_valid),
  .bid        (out_ch.best_bid),
  .offer_valid(out_ch.best_offer_valid),
  .offer      (out_ch.best_offer)
);

/* verif/tb_top_of_book_price_cache_core.sv */
// testbench of the top-of-book price cache: directed table, then random book traffic
// a local predictor of the book table checks every result in order
// depends on tobpc_pkg, tobpc_if and the top_of_book_price_cache_core rtl

module tb_top_of_book_price_cache_core;
  import tobpc_pkg::*;

  localparam int PW = PRICE_WIDTH_DEF;
  localparam int NB = NUM_BOOKS_DEF;
  localparam int ML = MAX_LEVELS_DEF;
  localparam logic [1:0] SIDE_OTHER = 2'd2;
  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

  typedef struct packed {
    logic [2:0]           command;
    logic [ID_W-1:0]      book_id;
    logic                 id_present;
    logic [1:0]           entry_side;
    logic                 price_present;
    logic signed [PW-1:0] price;
    logic                 first_entry;
    logic                 last_item;
  } item_t;

  typedef struct packed {
    logic                 bid_ok;
    logic signed [PW-1:0] bid;
    logic                 offer_ok;
    logic signed [PW-1:0] offer;
    logic [LEVEL_W-1:0]   bid_lv;
    logic [LEVEL_W-1:0]   offer_lv;
  } quote_t;

  typedef struct {
    item_t  it;
    logic   has_quote;
    quote_t q;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tobpc_in_if  #(.PW(PW)) in_ch ();
  tobpc_out_if #(.PW(PW)) out_ch ();

  top_of_book_price_cache_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  bit                   bk_on [NB];
  bit                   bk_bid_ok [NB];
  bit                   bk_off_ok [NB];
  logic signed [PW-1:0] bk_bid [NB];
  logic signed [PW-1:0] bk_off [NB];
  int                   bk_bid_n [NB];
  int                   bk_off_n [NB];
  logic signed [PW-1:0] seen_bid [ML];
  logic signed [PW-1:0] seen_off [ML];
  int                   st_bid_n, st_off_n;
  logic signed [PW-1:0] st_bid, st_off;
  int                   st_book;
  quote_t               agg;

  quote_t quotes_due[$];
  int     errors = 0;
  bit     done = 0;

  function automatic void add_level(ref logic signed [PW-1:0] seen [ML], ref int n,
                                    input logic signed [PW-1:0] p);
    for (int i = 0; i < n; i++)
      if (seen[i] == p) return;
    if (n < ML) begin
      seen[n] = p;
      n++;
    end
  endfunction

  function automatic void book_apply(item_t it);
    int b;
    bit known;
    b = int'(it.book_id);
    known = bk_on[b];
    case (it.command)
      CMD_REGISTER: if (!known) begin
        bk_on[b] = 1; bk_bid_ok[b] = 0; bk_off_ok[b] = 0;
        bk_bid[b] = '0; bk_off[b] = '0; bk_bid_n[b] = 0; bk_off_n[b] = 0;
      end
      CMD_SNAPSHOT: begin
        if (it.first_entry) begin
          st_bid_n = 0; st_off_n = 0; st_bid = '0; st_off = '0; st_book = b;
        end
        if (it.price_present && it.entry_side == SIDE_BID) begin
          if (st_bid_n == 0 || it.price > st_bid) st_bid = it.price;
          add_level(seen_bid, st_bid_n, it.price);
        end else if (it.price_present && it.entry_side == SIDE_OFFER) begin
          if (st_off_n == 0 || it.price < st_off) st_off = it.price;
          add_level(seen_off, st_off_n, it.price);
        end
        if (it.last_item) begin
          if (it.id_present && bk_on[st_book]) begin
            bk_bid_ok[st_book] = st_bid_n != 0;
            bk_bid[st_book] = st_bid_n != 0 ? st_bid : '0;
            bk_off_ok[st_book] = st_off_n != 0;
            bk_off[st_book] = st_off_n != 0 ? st_off : '0;
            bk_bid_n[st_book] = st_bid_n;
            bk_off_n[st_book] = st_off_n;
          end
          st_bid_n = 0; st_off_n = 0; st_bid = '0; st_off = '0;
        end
      end
      CMD_CLEAR: if (known) begin
        bk_bid_ok[b] = 0; bk_off_ok[b] = 0; bk_bid[b] = '0; bk_off[b] = '0;
        bk_bid_n[b] = 0; bk_off_n[b] = 0;
      end
      CMD_QUERY_OWN, CMD_QUERY_EXT: begin
        if (it.command == CMD_QUERY_OWN) begin
          agg = '0;
          if (known) begin
            agg.bid_ok = bk_bid_ok[b]; agg.bid = bk_bid[b];
            agg.offer_ok = bk_off_ok[b]; agg.offer = bk_off[b];
            agg.bid_lv = LEVEL_W'(bk_bid_n[b]); agg.offer_lv = LEVEL_W'(bk_off_n[b]);
          end
        end else if (known) begin
          if (bk_bid_ok[b] && (!agg.bid_ok || bk_bid[b] > agg.bid)) begin
            agg.bid_ok = 1; agg.bid = bk_bid[b];
          end
          if (bk_off_ok[b] && (!agg.offer_ok || bk_off[b] < agg.offer)) begin
            agg.offer_ok = 1; agg.offer = bk_off[b];
          end
        end
        if (it.last_item) begin
          quotes_due.push_back(agg);
          agg = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic item_t mk(logic [2:0] c, int b, bit idp, logic [1:0] s, bit pp,
                               logic signed [PW-1:0] p, bit f, bit l);
    item_t it;
    it.command = c; it.book_id = ID_W'(b); it.id_present = idp; it.entry_side = s;
    it.price_present = pp; it.price = p; it.first_entry = f; it.last_item = l;
    return it;
  endfunction

  function automatic int gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [PW-1:0] rand_price();
    return PW'({$urandom, $urandom});
  endfunction

  // pick a price, often from a small pool so levels repeat, sometimes the extremes or a random value
  function automatic logic signed [PW-1:0] pick_price();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return PMAX;
    if (r == 1) return PMIN;
    if (r < 6) return $signed(PW'($urandom_range(0, 40))) - 20;
    return rand_price();
  endfunction

  bit quiet_phase = 0;

  // called at a falling edge; valid stays up when the next item follows at once
  task automatic send(item_t it);
    int g;
    g = quiet_phase ? 0 : gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.command, in_ch.book_id, in_ch.id_present, in_ch.entry_side,
     in_ch.price_present, in_ch.price, in_ch.first_entry, in_ch.last_item} <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book_apply(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (quotes_due.size() != 0);
  endtask

  // result side
  int stall = 0;
  always @(negedge clk) begin
    if (stall > 0) begin
      stall <= stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      stall <= gap();
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    quote_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.best_bid_valid, out_ch.best_bid, out_ch.best_offer_valid,
             out_ch.best_offer, out_ch.bid_levels, out_ch.offer_levels};
      if (quotes_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = quotes_due.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: bid %0b/%0d offer %0b/%0d lv %0d/%0d, want %0b/%0d %0b/%0d %0d/%0d",
                     got.bid_ok, got.bid, got.offer_ok, got.offer, got.bid_lv, got.offer_lv,
                     want.bid_ok, want.bid, want.offer_ok, want.offer, want.bid_lv,
                     want.offer_lv);
        end
      end
    end
  end

  row_t dir_rows[$];

  task automatic add_row(item_t it, bit hq = 0, quote_t q = '0);
    row_t r;
    r.it = it; r.has_quote = hq; r.q = q;
    dir_rows.push_back(r);
  endtask

  initial begin
    item_t it;
    int b, n;
    in_ch.valid = 1'b0;
    in_ch.command = '0; in_ch.book_id = '0; in_ch.id_present = 1'b0;
    in_ch.entry_side = '0; in_ch.price_present = 1'b0; in_ch.price = '0;
    in_ch.first_entry = 1'b0; in_ch.last_item = 1'b0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NB; i++) begin
      bk_on[i] = 0; bk_bid_ok[i] = 0; bk_off_ok[i] = 0; bk_bid[i] = '0; bk_off[i] = '0;
      bk_bid_n[i] = 0; bk_off_n[i] = 0;
    end
    st_bid_n = 0; st_off_n = 0; st_bid = '0; st_off = '0; st_book = 0; agg = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: query after reset, extremes, skipped entries, dropped commit
    add_row(mk(CMD_QUERY_OWN, 15, 1, SIDE_BID, 1, '0, 0, 1), 1, '0);
    add_row(mk(CMD_REGISTER, 0, 1, SIDE_BID, 0, '0, 0, 0));
    add_row(mk(CMD_REGISTER, 15, 0, SIDE_OFFER, 1, PMAX, 1, 1));
    add_row(mk(CMD_QUERY_OWN, 0, 0, SIDE_BID, 0, '0, 0, 1), 1, '0);
    add_row(mk(CMD_SNAPSHOT, 0, 1, SIDE_BID, 1, PMIN, 1, 0));
    add_row(mk(CMD_SNAPSHOT, 9, 0, SIDE_BID, 1, PMAX, 0, 0));
    add_row(mk(CMD_SNAPSHOT, 0, 1, SIDE_OFFER, 1, PMAX, 0, 0));
    add_row(mk(CMD_SNAPSHOT, 0, 1, SIDE_OFFER, 1, PMIN, 0, 0));
    add_row(mk(CMD_SNAPSHOT, 0, 1, SIDE_OTHER, 1, '0, 0, 0));
    add_row(mk(CMD_SNAPSHOT, 0, 1, 2'd3, 1, 48'sd5, 0, 0));
    add_row(mk(CMD_SNAPSHOT, 0, 1, SIDE_BID, 0, 48'sd7, 0, 1));
    add_row(mk(CMD_QUERY_OWN, 0, 0, SIDE_BID, 0, '0, 0, 1), 1,
            '{1'b1, PMAX, 1'b1, PMIN, 6'd2, 6'd2});
    add_row(mk(CMD_SNAPSHOT, 15, 1, SIDE_BID, 1, 48'sd3, 1, 0));
    add_row(mk(CMD_SNAPSHOT, 15, 0, SIDE_OFFER, 1, 48'sd9, 0, 1));
    add_row(mk(CMD_SNAPSHOT, 15, 1, SIDE_OFFER, 1, 48'sd9, 1, 1));
    add_row(mk(CMD_SNAPSHOT, 4, 1, SIDE_BID, 1, 48'sd1, 1, 1));
    add_row(mk(CMD_QUERY_EXT, 15, 1, SIDE_BID, 1, '0, 1, 1), 1,
            '{1'b0, 48'sd0, 1'b1, 48'sd9, 6'd0, 6'd0});
    add_row(mk(CMD_QUERY_OWN, 15, 1, SIDE_BID, 1, '0, 1, 0));
    add_row(mk(CMD_QUERY_EXT, 0, 1, SIDE_BID, 1, '0, 1, 1));
    add_row(mk(3'd5, 0, 1, SIDE_BID, 1, '0, 1, 1));
    add_row(mk(3'd7, 15, 1, 2'd3, 1, PMAX, 1, 1));
    add_row(mk(CMD_CLEAR, 0, 1, SIDE_BID, 1, '0, 1, 1));
    add_row(mk(CMD_CLEAR, 3, 1, SIDE_BID, 1, '0, 1, 1));
    add_row(mk(CMD_QUERY_OWN, 0, 1, SIDE_OFFER, 1, PMIN, 1, 1), 1, '0);
    foreach (dir_rows[i]) begin
      send(dir_rows[i].it);
      // the item just accepted has its expected result at the back of the queue
      if (dir_rows[i].has_quote &&
          (quotes_due.size() == 0 || quotes_due[$] !== dir_rows[i].q)) begin
        errors++;
        $display("directed row %0d: predictor disagrees with table", i);
      end
    end
    drain();

    // random: mostly well-formed snapshots and queries with random content
    n = 0;
    while (n < 1000) begin
      int kind;
      kind = $urandom_range(0, 99);
      b = $urandom_range(0, NB - 1);
      if (n > 500 && n < 520) quiet_phase = 1;
      else quiet_phase = 0;
      if (n == 600) drain();
      if (kind < 10) begin
        send(mk(CMD_REGISTER, b, $urandom, $urandom, $urandom, rand_price(),
                $urandom, $urandom));
        n++;
      end else if (kind < 45) begin
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          it = mk(CMD_SNAPSHOT, b, $urandom_range(0, 15) != 0, $urandom_range(0, 9) == 0 ?
                  $urandom_range(2, 3) : $urandom_range(0, 1), $urandom_range(0, 15) != 0,
                  pick_price(), k == 0, k == len - 1);
          if ($urandom_range(0, 29) == 0) it.first_entry = ~it.first_entry;
          send(it);
          n++;
        end
      end else if (kind < 52) begin
        send(mk(CMD_CLEAR, b, $urandom, $urandom, $urandom, rand_price(),
                $urandom, $urandom));
        n++;
      end else if (kind < 95) begin
        int ext;
        ext = $urandom_range(0, 3);
        it = mk($urandom_range(0, 9) == 0 ? CMD_QUERY_EXT : CMD_QUERY_OWN, b, $urandom,
                $urandom, $urandom, rand_price(), $urandom, ext == 0);
        send(it);
        n++;
        for (int k = 0; k < ext; k++) begin
          send(mk(CMD_QUERY_EXT, $urandom_range(0, NB - 1), $urandom, $urandom, $urandom,
                  rand_price(), $urandom, k == ext - 1));
          n++;
        end
      end else begin
        send(mk($urandom_range(5, 7), b, $urandom, $urandom, $urandom, rand_price(),
                $urandom, $urandom));
      end
    end
    drain();
    repeat (200) @(posedge clk);
    done = 1;
    if (errors == 0 && quotes_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20000000;
    if (!done) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
